### src/srmis_pkg.sv
// Package for the sparse row max inverse square root scaler.
// Holds shared widths, constants and the queue entry type; no dependencies.
`default_nettype none
package srmis_pkg;
   localparam int WordWidth = 64;
   localparam int QueueDepthDefault = 4;
   localparam logic [63:0] AbsMask = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
   localparam logic [52:0] OneMant = 53'h10_0000_0000_0000;

   typedef struct packed {
      logic [63:0] max_bits;
   } row_type;
endpackage
`default_nettype wire

### src/srmis_if.sv
// Valid/ready channel interfaces for the scaler.
// Depends on nothing but carries 64-bit payloads.
`default_nettype none
interface srmis_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] entry_bits;
   logic        entry_present;
   logic        row_end;
   modport source (output valid, entry_bits, entry_present, row_end, input ready);
   modport sink (input valid, entry_bits, entry_present, row_end, output ready);
endinterface

interface srmis_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] scale_bits;
   modport source (output valid, scale_bits, input ready);
   modport sink (input valid, scale_bits, output ready);
endinterface
`default_nettype wire

### src/sparse_row_max_inverse_sqrt_scale.sv
// Top level of the sparse row max inverse square root scaler.
// Depends on srmis_pkg, srmis_if, srmis_front, srmis_queue and srmis_back.
//
// Usage: the req channel carries one matrix value per transaction
// (entry_bits, entry_present, row_end). The front end folds each value into
// the running magnitude maximum in the cycle it is accepted, so values stream
// at one per cycle while the queue has space. A transaction with row_end set
// closes the row and pushes its maximum into a small queue. The back end pops
// one maximum at a time, normalizes it, runs a 53-step square root recurrence
// and a 56-step reciprocal division, and returns 1/sqrt(max) on the rsp
// channel. A subnormal maximum is normalized one bit per cycle. Rows may
// arrive faster than the back end answers them only as long as the queue has
// space, after which req.ready drops. Zero and infinite maxima answer in the
// cycle after they are popped. Reset clears the maximum to +0, empties the
// queue and drops any pending result. While the receiver stalls, the result
// is held and the queue fills behind it.
`default_nettype none
module sparse_row_max_inverse_sqrt_scale
   import srmis_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  wire logic   clock,
   input  wire logic   reset,
   srmis_req_if.sink   req,
   srmis_rsp_if.source rsp
);
   logic    push_valid, push_ready, pop_valid, pop_ready;
   row_type push_data, pop_data;

   srmis_front u_front (.clock, .reset, .req, .push_ready, .push_valid, .push_data);
   srmis_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .in_valid(push_valid), .in_ready(push_ready), .in_data(push_data),
      .out_valid(pop_valid), .out_ready(pop_ready), .out_data(pop_data));
   srmis_back u_back (.clock, .reset, .pop_valid, .pop_ready, .pop_data, .rsp);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.scale_bits))
      else $error("result changed while stalled");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> !rsp.valid) else $error("pop while result pending");
   a_ready_queue: assert property (@(posedge clock) disable iff (reset)
      req.ready == push_ready) else $error("ready not tied to queue space");
endmodule
`default_nettype wire

### src/srmis_front.sv
// Front end: tracks the running row maximum and pushes closed rows.
// Depends on srmis_pkg and srmis_if.
`default_nettype none
module srmis_front
   import srmis_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   srmis_req_if.sink    req,
   input  wire logic    push_ready,
   output logic         push_valid,
   output row_type      push_data
);
   logic [63:0] max_ff, max_in, mag, upd;

   assign req.ready = push_ready;
   assign mag = req.entry_bits & AbsMask;
   always_comb begin
      upd = max_ff;
      if (req.entry_present && mag <= PosInf && mag > max_ff) upd = mag;
   end
   assign push_valid = req.valid && req.row_end;
   assign push_data.max_bits = upd;

   always_comb begin
      max_in = max_ff;
      if (req.valid && req.ready) max_in = req.row_end ? 64'd0 : upd;
   end

   always_ff @(posedge clock) begin
      if (reset) max_ff <= '0;
      else max_ff <= max_in;
   end
endmodule
`default_nettype wire

### src/srmis_queue.sv
// Small FIFO between front and back ends.
// Depends on srmis_pkg.
`default_nettype none
module srmis_queue
   import srmis_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  row_type   in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output row_type   out_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   row_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic wr, rd;

   assign in_ready = cnt_ff != Depth[AW:0];
   assign out_valid = cnt_ff != '0;
   assign out_data = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
   end
endmodule
`default_nettype wire

### src/srmis_back.sv
// Back end: digit-recurrence square root then restoring reciprocal divide.
// Depends on srmis_pkg and srmis_if.
`default_nettype none
module srmis_back
   import srmis_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  pop_valid,
   output logic       pop_ready,
   input  row_type    pop_data,
   srmis_rsp_if.source rsp
);
   localparam logic [1:0] StIdle = 2'd0, StNorm = 2'd1, StSqrt = 2'd2, StDiv = 2'd3;
   logic [1:0]   st_ff, st_in;
   logic [63:0]  x_ff, x_in;
   logic [11:0]  f_ff, f_in;      // biased exponent of m plus 125
   logic [5:0]   i_ff, i_in;
   logic [56:0]  rem_ff, rem_in;
   logic [55:0]  root_ff, root_in;
   logic         vld_ff, vld_in;
   logic [63:0]  out_ff, out_in;
   logic [56:0]  trial, rq;
   logic [1:0]   pair;
   logic [52:0]  r53;
   logic [10:0]  se, oe;
   logic [55:0]  q;

   assign pop_ready = st_ff == StIdle && !vld_ff;
   assign rsp.valid = vld_ff;
   assign rsp.scale_bits = out_ff;
   assign pair = (i_ff >= 6'd26) ? 2'(x_ff[53:0] >> (2 * i_ff - 6'd52)) : 2'd0;
   assign trial = {root_ff[54:0], 2'b01};
   assign rq = {rem_ff[54:0], pair};
   // Rounded root, valid once the recurrence ends.
   assign r53 = (rem_ff > {1'b0, root_ff}) ? root_ff[52:0] + 1'b1 : root_ff[52:0];
   assign q = root_ff;

   always_comb begin
      st_in = st_ff; x_in = x_ff; f_in = f_ff; i_in = i_ff;
      rem_in = rem_ff; root_in = root_ff; vld_in = vld_ff; out_in = out_ff;
      se = '0; oe = '0;
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      case (st_ff)
         StIdle: begin
            if (pop_valid && pop_ready) begin
               if (pop_data.max_bits == '0) begin
                  out_in = PosInf; vld_in = 1'b1;
               end else if (pop_data.max_bits >= PosInf) begin
                  out_in = '0; vld_in = 1'b1;
               end else begin
                  if (pop_data.max_bits[62:52] == '0) begin
                     x_in = {12'd0, pop_data.max_bits[51:0]};
                     f_in = 12'd126;
                  end else begin
                     x_in = {11'd0, 1'b1, pop_data.max_bits[51:0]};
                     f_in = 12'(pop_data.max_bits[62:52]) + 12'd125;
                  end
                  st_in = StNorm;
               end
            end
         end
         StNorm: begin
            if (!x_ff[52]) begin
               x_in = x_ff << 1; f_in = f_ff - 1'b1;
            end else begin
               if (f_ff[0]) begin
                  x_in = x_ff << 1; f_in = f_ff - 1'b1;
               end
               i_in = 6'd52; rem_in = '0; root_in = '0; st_in = StSqrt;
            end
         end
         StSqrt: begin
            if (rq >= trial) begin
               rem_in = rq - trial; root_in = {root_ff[54:0], 1'b1};
            end else begin
               rem_in = rq; root_in = {root_ff[54:0], 1'b0};
            end
            i_in = i_ff - 1'b1;
            if (i_ff == '0) st_in = StDiv;
            if (st_ff == StSqrt && i_ff == '0) begin end
         end
         StDiv: begin
            // First entry: rounded root is set up as divisor in x, quotient in root.
            if (i_ff == 6'h3F) begin
               if (rem_ff > {1'b0, root_ff} &&
                   root_ff[52:0] == 53'h1F_FFFF_FFFF_FFFF) begin
                  x_in = {11'd0, OneMant}; f_in = f_ff + 12'd2;
               end else begin
                  x_in = {11'd0, r53};
               end
               rem_in = {4'd0, OneMant}; root_in = '0; i_in = 6'd55;
            end else begin
               if (rem_ff >= {4'd0, x_ff[52:0]}) begin
                  rem_in = (rem_ff - {4'd0, x_ff[52:0]}) << 1;
                  root_in = {root_ff[54:0], 1'b1};
               end else begin
                  rem_in = rem_ff << 1; root_in = {root_ff[54:0], 1'b0};
               end
               i_in = i_ff - 1'b1;
               if (i_ff == '0) begin
                  se = 11'(f_ff >> 1) + 11'd449 - 11'd600;
                  st_in = StIdle; vld_in = 1'b1;
                  out_in = '0;
                  if (x_ff[52:0] == OneMant) begin
                     oe = 11'd2046 - 11'(f_ff >> 1) - 11'd449;
                     out_in = {1'b0, oe, 52'd0};
                  end else begin
                     // root_in holds 56 quotient bits of 2^55/d scaled, leading bit at 54.
                     oe = 11'd2045 - 11'(f_ff >> 1) - 11'd449;
                     out_in = {1'b0, oe, root_in[53:2]} + 64'(root_in[1] &
                              (root_in[0] | (rem_in != '0) | root_in[2]));
                  end
                  if (se == '0) out_in = out_in;
               end
            end
         end
         default: st_in = StIdle;
      endcase
      if (st_ff == StSqrt && i_ff == '0) i_in = 6'h3F;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
      end
      x_ff <= x_in; f_ff <= f_in; i_ff <= i_in; rem_ff <= rem_in;
      root_ff <= root_in; out_ff <= out_in;
   end
   logic unused;
   assign unused = ^q;
endmodule
`default_nettype wire

### tb/sv/sparse_row_max_inverse_sqrt_scale_tb.sv
// Testbench for sparse_row_max_inverse_sqrt_scale: rows of doubles in, 1/sqrt(row max) out.
// Depends on srmis_pkg, srmis_if and the scaler RTL; self-checking, needs no files.
`timescale 1ns / 1ps
`default_nettype none
module sparse_row_max_inverse_sqrt_scale_tb;
   import srmis_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srmis_req_if req ();
   srmis_rsp_if rsp ();

   sparse_row_max_inverse_sqrt_scale dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Expected scale factors, oldest first, and the predictor's own copy of the
   // row maximum magnitude (bits of a nonnegative double, +0 after reset).
   logic [63:0] scale_expected_q[$];
   logic [63:0] row_peak_mag = '0;

   int error_count = 0;
   int entry_count = 0;
   int row_count = 0;
   int idle_cycles = 0;
   bit idle_enable = 1'b1;
   int hold_request = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // The square root is rounded once, then the reciprocal is rounded once, both
   // by the simulator's double arithmetic. Zero and infinity are answered directly.
   function automatic logic [63:0] inv_sqrt_of_peak(input logic [63:0] peak);
      real root;
      if (peak == '0) return PosInf;
      if (peak >= PosInf) return '0;
      root = $sqrt($bitstoreal(peak));
      return $realtobits(1.0 / root);
   endfunction

   // Monitor: values are sampled before the edge updates anything, so a
   // transaction seen here is exactly one the block accepted at this edge.
   always @(posedge clock) begin
      logic [63:0] mag;
      logic [63:0] got;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
      if (!reset && req.valid && req.ready) begin
         entry_count++;
         if (req.entry_present) begin
            mag = req.entry_bits & AbsMask;
            // NaN magnitudes lie above +inf and are dropped; ties change nothing.
            if (mag <= PosInf && mag > row_peak_mag) row_peak_mag = mag;
         end
         if (req.row_end) begin
            scale_expected_q.push_back(inv_sqrt_of_peak(row_peak_mag));
            row_peak_mag = '0;
            row_count++;
         end
      end
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.scale_bits;
         if (scale_expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
         end else if (got !== scale_expected_q[0]) begin
            report_mismatch($sformatf("scale_bits %h, expected %h", got, scale_expected_q[0]));
            void'(scale_expected_q.pop_front());
         end else begin
            void'(scale_expected_q.pop_front());
         end
      end
   end

   // Receiver: random stalls, or a long counted hold-off when asked for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_request > 0) begin
         rsp.ready <= 1'b0;
         hold_request <= hold_request - 1;
      end else if (idle_enable) begin
         rsp.ready <= ($urandom_range(99) >= 25);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offers one transaction and returns once it has been accepted. Valid stays
   // high afterward so back-to-back transactions stream without a gap.
   task automatic send_entry(input logic [63:0] bits, input logic present, input logic last);
      if (idle_enable && $urandom_range(99) < 25) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.entry_bits <= bits;
      req.entry_present <= present;
      req.row_end <= last;
      do @(posedge clock); while (!req.ready);
   endtask

   // Random double drawn across the interesting classes, either sign.
   function automatic logic [63:0] random_double();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(15))
         0: v[62:0] = '0;                             // zero
         1: v[62:0] = PosInf[62:0];                   // infinity
         2: v[62:52] = '1;                            // NaN or infinity
         3: v[62:52] = '0;                            // subnormal
         4: v[62:52] = 11'h3FF;                       // near one, close ties
         5: v[62:0] = {11'h7FE, 52'hF_FFFF_FFFF_FFFF}; // largest finite
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_random_row(input int max_len);
      int len;
      len = $urandom_range(0, max_len);
      for (int i = 0; i < len; i++) send_entry(random_double(), $urandom_range(0, 7) != 0, 1'b0);
      // The closing transaction carries a value half the time.
      send_entry(random_double(), $urandom_range(1), 1'b1);
   endtask

   task automatic test_directed();
      send_entry('0, 1'b0, 1'b1);                                // empty row
      send_entry(64'h8000_0000_0000_0000, 1'b1, 1'b1);           // negative zero only
      send_entry(64'h3FF0_0000_0000_0000, 1'b1, 1'b1);           // entry with row end
      send_entry(64'hC010_0000_0000_0000, 1'b1, 1'b0);           // -4
      send_entry(64'h4000_0000_0000_0000, 1'b1, 1'b0);           // 2 is not larger
      send_entry(64'h4010_0000_0000_0000, 1'b1, 1'b0);           // equal magnitude
      send_entry(64'h7FF8_0000_0000_0001, 1'b1, 1'b0);           // NaN ignored
      send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);           // negative NaN ignored
      send_entry(64'hFFF0_0000_0000_0000, 1'b1, 1'b0);           // -inf
      send_entry(64'h3FF0_0000_0000_0000, 1'b1, 1'b1);           // row closes at inf
      send_entry(64'h0000_0000_0000_0001, 1'b1, 1'b1);           // smallest subnormal
      send_entry(64'h800F_FFFF_FFFF_FFFF, 1'b1, 1'b1);           // largest subnormal
      send_entry(64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 1'b1);           // largest finite
      send_entry(64'h0010_0000_0000_0000, 1'b1, 1'b1);           // smallest normal
      send_entry(64'h7FF0_0000_0000_0000, 1'b0, 1'b1);           // absent inf is ignored
      send_entry(64'h4008_0000_0000_0000, 1'b1, 1'b0);           // 3 then closed bare
      send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
      send_entry(64'h4000_0000_0000_0000, 1'b1, 1'b1);           // root of 2 is inexact
      send_entry(64'h4010_0000_0000_0000, 1'b1, 1'b1);           // exact root of 4
   endtask

   task automatic test_random_rows(input int rows);
      for (int r = 0; r < rows; r++) send_random_row(8);
   endtask

   // Rows closed back to back while the receiver holds off: the queue fills
   // and the block must stall its input without losing anything.
   task automatic test_back_pressure();
      hold_request <= 600;
      for (int r = 0; r < 40; r++) send_random_row(1);
   endtask

   task automatic test_streaming();
      idle_enable = 1'b0;
      test_random_rows(25);
      idle_enable = 1'b1;
   endtask

   initial begin
      req.valid = 1'b0;
      req.entry_bits = '0;
      req.entry_present = 1'b0;
      req.row_end = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_rows(110);
      test_back_pressure();
      test_streaming();
      test_random_rows(80);

      req.valid <= 1'b0;
      wait (scale_expected_q.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (scale_expected_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", scale_expected_q.size()));

      $display("covered %0d transactions in %0d rows: empty, signed zero, NaN, infinity,",
               entry_count, row_count);
      $display("subnormal and extreme values, random idling and a long receiver hold-off");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
